>>> hdl/image_pixel_statistics_defines.svh
// Assertion macros used by the checker file.
`ifndef IMAGE_PIXEL_STATISTICS_DEFINES_SVH
`define IMAGE_PIXEL_STATISTICS_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define IPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/ips_pkg.sv
`timescale 1ns / 1ps

package ips_pkg;

   localparam int PIXEL_BITS = 16;
   localparam int COUNT_BITS = 24;

   // port widths of the beats
   localparam int IN_PIX_W = 16;
   localparam int VAL_W    = 16;
   localparam int OCNT_W   = 25;
   localparam int MEAN_W   = 24;
   localparam int STD_W    = 23;

   localparam int MEAN_SHIFT = 8;
   localparam int STD_SHIFT  = 16;

   localparam int CNT_W  = COUNT_BITS + 1;
   localparam int SUM_W  = PIXEL_BITS + COUNT_BITS;
   localparam int PSQ_W  = 2 * PIXEL_BITS;
   localparam int SQ_W   = PSQ_W + COUNT_BITS;
   localparam int NUM_W  = CNT_W + SQ_W;
   localparam int DEN_W  = 2 * CNT_W;
   localparam int DIVD_W = NUM_W + STD_SHIFT;
   localparam int ROOT_W = PIXEL_BITS + MEAN_SHIFT;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int SREM_W = ROOT_W + 2;
   localparam int SQSH_W = ROOT_W + 4;

   localparam int MAX_STEPS = (SUM_W > ROOT_W) ? SUM_W : ROOT_W;
   localparam int STEP_W    = $clog2(MAX_STEPS + 1);
   localparam int DCNT_W    = $clog2(DIVD_W + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // accumulated totals of one image
   typedef struct packed {
      logic [PIXEL_BITS-1:0] min_v;
      logic [PIXEL_BITS-1:0] max_v;
      logic [CNT_W-1:0]      count;
      logic [SUM_W-1:0]      sum;
      logic [SQ_W-1:0]       sum_sq;
      logic                  overflow;
   } ips_snap_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ips_queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL_SQ,
      BK_MUL_SS,
      BK_DIV_MEAN,
      BK_DIV_VAR,
      BK_SQRT,
      BK_DONE
   } ips_back_state_type;

endpackage

>>> hdl/ips_front.sv
`timescale 1ns / 1ps

module ips_front import ips_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [IN_PIX_W-1:0]  req_pixel,
   input  logic                 req_last,
   input  ips_queue_status_type q_status,
   output logic                 push,
   output ips_snap_type         push_data
);

   logic                  a_valid_ff, a_valid_in;
   logic                  a_last_ff, a_last_in;
   logic [PIXEL_BITS-1:0] a_pix_ff, a_pix_in;
   logic [PSQ_W-1:0]      a_sq_ff, a_sq_in;

   logic [PIXEL_BITS-1:0] min_ff, min_in, max_ff, max_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic                  ovf_ff, ovf_in;

   logic                  stall, take, go, at_limit;
   logic [PIXEL_BITS-1:0] pix;
   ips_snap_type          upd;

   assign pix       = PIXEL_BITS'(req_pixel);
   // a closing beat waits in the input stage until the queue has room
   assign stall     = a_valid_ff && a_last_ff && q_status.full;
   assign req_ready = !stall;
   assign take      = req_valid && req_ready;
   assign go        = a_valid_ff && !stall;
   assign at_limit  = cnt_ff[CNT_W-1];

   always_comb begin
      a_valid_in = a_valid_ff;
      a_last_in  = a_last_ff;
      a_pix_in   = a_pix_ff;
      a_sq_in    = a_sq_ff;
      if (!stall) begin
         a_valid_in = take;
      end
      if (take) begin
         a_last_in = req_last;
         a_pix_in  = pix;
         a_sq_in   = PSQ_W'(pix) * PSQ_W'(pix);
      end
   end

   always_comb begin
      upd.min_v    = min_ff;
      upd.max_v    = max_ff;
      upd.count    = cnt_ff;
      upd.sum      = sum_ff;
      upd.sum_sq   = sq_ff;
      upd.overflow = ovf_ff;
      if (!at_limit) begin
         if (cnt_ff == '0) begin
            upd.min_v = a_pix_ff;
            upd.max_v = a_pix_ff;
         end else begin
            if (a_pix_ff < min_ff) upd.min_v = a_pix_ff;
            if (a_pix_ff > max_ff) upd.max_v = a_pix_ff;
         end
         upd.count  = cnt_ff + CNT_W'(1);
         upd.sum    = sum_ff + SUM_W'(a_pix_ff);
         upd.sum_sq = sq_ff + SQ_W'(a_sq_ff);
      end else begin
         upd.overflow = 1'b1;
      end
   end

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      sq_in  = sq_ff;
      ovf_in = ovf_ff;
      if (go) begin
         if (a_last_ff) begin
            min_in = '0;
            max_in = '0;
            cnt_in = '0;
            sum_in = '0;
            sq_in  = '0;
            ovf_in = 1'b0;
         end else begin
            min_in = upd.min_v;
            max_in = upd.max_v;
            cnt_in = upd.count;
            sum_in = upd.sum;
            sq_in  = upd.sum_sq;
            ovf_in = upd.overflow;
         end
      end
   end

   assign push      = go && a_last_ff;
   assign push_data = upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         a_last_ff  <= 1'b0;
         min_ff     <= '0;
         max_ff     <= '0;
         cnt_ff     <= '0;
         sum_ff     <= '0;
         sq_ff      <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         a_last_ff  <= a_last_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         cnt_ff     <= cnt_in;
         sum_ff     <= sum_in;
         sq_ff      <= sq_in;
         ovf_ff     <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      a_pix_ff <= a_pix_in;
      a_sq_ff  <= a_sq_in;
   end

endmodule

>>> hdl/ips_queue.sv
`timescale 1ns / 1ps

module ips_queue import ips_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ips_snap_type         push_data,
   input  logic                 pop,
   output ips_snap_type         pop_data,
   output ips_queue_status_type status
);

   ips_snap_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> hdl/ips_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle over the whole dividend.
module ips_div import ips_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DEN_W-1:0]  divisor,
   output logic              done,
   output logic [RAD_W-1:0]  quotient
);

   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVD_W-1:0] dvd_ff, dvd_in;
   logic [DEN_W-1:0]  dvs_ff, dvs_in, rem_ff, rem_in;
   logic [RAD_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]    trial, diff;
   logic              fits;

   assign trial = {rem_ff, dvd_ff[DIVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[RAD_W-2:0], fits};
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DIVD_W);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

>>> hdl/ips_back.sv
`timescale 1ns / 1ps

module ips_back import ips_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ips_queue_status_type q_status,
   input  ips_snap_type         pop_data,
   output logic                 pop,
   output logic                 div_start,
   output logic [DIVD_W-1:0]    div_dividend,
   output logic [DEN_W-1:0]     div_divisor,
   input  logic                 div_done,
   input  logic [RAD_W-1:0]     div_quotient,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VAL_W-1:0]     rsp_min_value,
   output logic [VAL_W-1:0]     rsp_max_value,
   output logic [OCNT_W-1:0]    rsp_pixel_count,
   output logic [MEAN_W-1:0]    rsp_mean_q8,
   output logic [STD_W-1:0]     rsp_std_q8,
   output logic                 rsp_count_overflow
);

   ips_back_state_type state_ff, state_in;

   logic [PIXEL_BITS-1:0] s_min_ff, s_min_in, s_max_ff, s_max_in;
   logic [CNT_W-1:0]      s_cnt_ff, s_cnt_in;
   logic [SUM_W-1:0]      s_sum_ff, s_sum_in;
   logic                  s_ovf_ff, s_ovf_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [NUM_W-1:0]      acc_ff, acc_in, mcand_ff, mcand_in;
   logic [SUM_W-1:0]      mplier_ff, mplier_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [MEAN_W-1:0]     mean_ff, mean_in;
   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [SREM_W-1:0]     srem_ff, srem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;

   logic                  rv_ff, rv_in;
   logic [VAL_W-1:0]      r_min_ff, r_min_in, r_max_ff, r_max_in;
   logic [OCNT_W-1:0]     r_cnt_ff, r_cnt_in;
   logic [MEAN_W-1:0]     r_mean_ff, r_mean_in;
   logic [STD_W-1:0]      r_std_ff, r_std_in;
   logic                  r_ovf_ff, r_ovf_in;

   logic [SQSH_W-1:0]     sq_sh, sq_trial;

   // two radicand bits come in per root bit
   assign sq_sh    = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign sq_trial = SQSH_W'({root_ff, 2'b01});

   always_comb begin
      state_in  = state_ff;
      s_min_in  = s_min_ff;
      s_max_in  = s_max_ff;
      s_cnt_in  = s_cnt_ff;
      s_sum_in  = s_sum_ff;
      s_ovf_in  = s_ovf_ff;
      den_in    = den_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      step_in   = step_ff;
      mean_in   = mean_ff;
      rad_in    = rad_ff;
      srem_in   = srem_ff;
      root_in   = root_ff;
      rv_in     = rv_ff && !rsp_ready;
      r_min_in  = r_min_ff;
      r_max_in  = r_max_ff;
      r_cnt_in  = r_cnt_ff;
      r_mean_in = r_mean_ff;
      r_std_in  = r_std_ff;
      r_ovf_in  = r_ovf_ff;
      pop          = 1'b0;
      div_start    = 1'b0;
      div_dividend = DIVD_W'(acc_ff) << STD_SHIFT;
      div_divisor  = den_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop       = 1'b1;
               s_min_in  = pop_data.min_v;
               s_max_in  = pop_data.max_v;
               s_cnt_in  = pop_data.count;
               s_sum_in  = pop_data.sum;
               s_ovf_in  = pop_data.overflow;
               den_in    = DEN_W'(pop_data.count) * DEN_W'(pop_data.count);
               acc_in    = '0;
               mcand_in  = NUM_W'(pop_data.sum_sq);
               mplier_in = SUM_W'(pop_data.count);
               step_in   = STEP_W'(CNT_W);
               state_in  = BK_MUL_SQ;
            end
         end
         // acc = n * sum2, shift-and-add over the bits of n
         BK_MUL_SQ: begin
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               mcand_in  = NUM_W'(s_sum_ff);
               mplier_in = s_sum_ff;
               step_in   = STEP_W'(SUM_W);
               state_in  = BK_MUL_SS;
            end
         end
         // acc -= sum * sum; never drops below zero on the way
         BK_MUL_SS: begin
            if (mplier_ff[0]) acc_in = acc_ff - mcand_ff;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               div_start    = 1'b1;
               div_dividend = DIVD_W'(s_sum_ff) << MEAN_SHIFT;
               div_divisor  = DEN_W'(s_cnt_ff);
               state_in     = BK_DIV_MEAN;
            end
         end
         BK_DIV_MEAN: begin
            if (div_done) begin
               mean_in   = MEAN_W'(div_quotient);
               div_start = 1'b1;
               state_in  = BK_DIV_VAR;
            end
         end
         BK_DIV_VAR: begin
            if (div_done) begin
               rad_in   = div_quotient;
               srem_in  = '0;
               root_in  = '0;
               step_in  = STEP_W'(ROOT_W);
               state_in = BK_SQRT;
            end
         end
         BK_SQRT: begin
            if (sq_sh >= sq_trial) begin
               srem_in = SREM_W'(sq_sh - sq_trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = SREM_W'(sq_sh);
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            rad_in  = rad_ff << 2;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) state_in = BK_DONE;
         end
         BK_DONE: begin
            if (!rv_ff || rsp_ready) begin
               rv_in     = 1'b1;
               r_min_in  = VAL_W'(s_min_ff);
               r_max_in  = VAL_W'(s_max_ff);
               r_cnt_in  = OCNT_W'(s_cnt_ff);
               r_mean_in = mean_ff;
               r_std_in  = STD_W'(root_ff);
               r_ovf_in  = s_ovf_ff;
               state_in  = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign rsp_valid          = rv_ff;
   assign rsp_min_value      = r_min_ff;
   assign rsp_max_value      = r_max_ff;
   assign rsp_pixel_count    = r_cnt_ff;
   assign rsp_mean_q8        = r_mean_ff;
   assign rsp_std_q8         = r_std_ff;
   assign rsp_count_overflow = r_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         step_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      s_min_ff  <= s_min_in;
      s_max_ff  <= s_max_in;
      s_cnt_ff  <= s_cnt_in;
      s_sum_ff  <= s_sum_in;
      s_ovf_ff  <= s_ovf_in;
      den_ff    <= den_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      mean_ff   <= mean_in;
      rad_ff    <= rad_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
      r_min_ff  <= r_min_in;
      r_max_ff  <= r_max_in;
      r_cnt_ff  <= r_cnt_in;
      r_mean_ff <= r_mean_in;
      r_std_ff  <= r_std_in;
      r_ovf_ff  <= r_ovf_in;
   end

endmodule

>>> hdl/image_pixel_statistics.sv
`timescale 1ns / 1ps

// Pixel statistics over one image: min, max, count, mean and population
// standard deviation, the last two unsigned with 8 fraction bits.
// req_ channel: one pixel per beat, req_last on the final pixel of an image.
// Pixels are taken one per cycle; the front end squares and accumulates them.
// rsp_ channel: one beat per image, issued after the beat marked last.
// The front end hands the image totals to a two-deep queue; the back end then
// works them out serially: n*sum2 and sum*sum by shift-and-add, two passes of
// a restoring divider (mean, then variance) and a bit-serial square root. The
// back end pops no new image before the last is done; the divider takes most.
// While both queue entries are taken, a last pixel waits in the input stage
// and req_ready drops.
// A stalled rsp_ holds its beat in the output register while the back end
// goes on with the next image.
// Pixels beyond 2^24 in one image are dropped and flagged in the result.
// Reset (synchronous) clears the totals, empties the queue and drops rsp_valid.
module image_pixel_statistics import ips_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [IN_PIX_W-1:0] req_pixel,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VAL_W-1:0]    rsp_min_value,
   output logic [VAL_W-1:0]    rsp_max_value,
   output logic [OCNT_W-1:0]   rsp_pixel_count,
   output logic [MEAN_W-1:0]   rsp_mean_q8,
   output logic [STD_W-1:0]    rsp_std_q8,
   output logic                rsp_count_overflow
);

   ips_queue_status_type q_status;
   ips_snap_type         push_data, pop_data;
   logic                 push, pop;
   logic                 div_start, div_done;
   logic [DIVD_W-1:0]    div_dividend;
   logic [DEN_W-1:0]     div_divisor;
   logic [RAD_W-1:0]     div_quotient;

   ips_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pixel (req_pixel),
      .req_last  (req_last),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   ips_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   ips_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   ips_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .pop_data           (pop_data),
      .pop                (pop),
      .div_start          (div_start),
      .div_dividend       (div_dividend),
      .div_divisor        (div_divisor),
      .div_done           (div_done),
      .div_quotient       (div_quotient),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_min_value      (rsp_min_value),
      .rsp_max_value      (rsp_max_value),
      .rsp_pixel_count    (rsp_pixel_count),
      .rsp_mean_q8        (rsp_mean_q8),
      .rsp_std_q8         (rsp_std_q8),
      .rsp_count_overflow (rsp_count_overflow)
   );

endmodule

>>> hdl/ips_checker.sv
`timescale 1ns / 1ps
`include "image_pixel_statistics_defines.svh"

module ips_checker import ips_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [VAL_W-1:0]    rsp_min_value,
   input logic [VAL_W-1:0]    rsp_max_value,
   input logic [OCNT_W-1:0]   rsp_pixel_count,
   input logic [MEAN_W-1:0]   rsp_mean_q8,
   input logic [STD_W-1:0]    rsp_std_q8,
   input logic                rsp_count_overflow
);

   logic [MEAN_W-1:0] min_q8, max_q8;
   logic [OCNT_W-1:0] count_limit;

   assign min_q8      = MEAN_W'(rsp_min_value) << MEAN_SHIFT;
   assign max_q8      = MEAN_W'(rsp_max_value) << MEAN_SHIFT;
   assign count_limit = OCNT_W'(1) << COUNT_BITS;

   `IPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_std_q8), "beat dropped")
   `IPS_ASSERT_NOW(a_count_nz, rsp_valid, rsp_pixel_count != '0, "empty image reported")
   `IPS_ASSERT_NOW(a_min_max, rsp_valid, rsp_min_value <= rsp_max_value, "min above max")
   `IPS_ASSERT_NOW(a_mean_rng, rsp_valid, rsp_mean_q8 >= min_q8 && rsp_mean_q8 <= max_q8, "mean out")
   `IPS_ASSERT_NOW(a_ovf_full, rsp_valid && rsp_count_overflow, rsp_pixel_count == count_limit, "ovf")

endmodule

bind image_pixel_statistics ips_checker u_ips_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb import ips_pkg::*;;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int RANDOM_ITEMS = 1550;
   localparam int HOLD_CYCLES  = 3000;
   localparam int DRAIN_CYCLES = 400;
   localparam int N_DIRECTED   = 18;

   typedef struct packed {
      logic [VAL_W-1:0]  min_value;
      logic [VAL_W-1:0]  max_value;
      logic [OCNT_W-1:0] pixel_count;
      logic [MEAN_W-1:0] mean_q8;
      logic [STD_W-1:0]  std_q8;
      logic              count_overflow;
   } image_stats_type;

   typedef struct packed {
      logic [IN_PIX_W-1:0] pixel;
      logic                last;
      logic                typed;
      image_stats_type     want;
   } pixel_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [IN_PIX_W-1:0] req_pixel;
   logic                req_last;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [VAL_W-1:0]    rsp_min_value;
   logic [VAL_W-1:0]    rsp_max_value;
   logic [OCNT_W-1:0]   rsp_pixel_count;
   logic [MEAN_W-1:0]   rsp_mean_q8;
   logic [STD_W-1:0]    rsp_std_q8;
   logic                rsp_count_overflow;

   // running totals of the image being streamed in
   logic [PIXEL_BITS-1:0] acc_min;
   logic [PIXEL_BITS-1:0] acc_max;
   logic [CNT_W-1:0]      acc_count;
   logic [63:0]           acc_sum;
   logic [63:0]           acc_sum_sq;
   logic                  acc_overflow;

   image_stats_type pending_stats[$];
   int              fail_count = 0;
   int              images_closed = 0;
   int              results_taken = 0;
   int              items_sent = 0;
   int              cycle_count = 0;
   bit              sender_quiet = 0;
   bit              hold_done = 0;

   // zero pixels, full scale, two-pixel extremes, constant image, first pixel
   // in the middle of the range, alternating bit patterns
   pixel_row_type directed_rows [N_DIRECTED] = '{
      '{16'd0,     1'b1, 1'b1, '{16'd0,     16'd0,     25'd1, 24'd0,        23'd0,       1'b0}},
      '{16'd65535, 1'b1, 1'b1, '{16'd65535, 16'd65535, 25'd1, 24'd16776960, 23'd0,       1'b0}},
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'd65535, 1'b1, 1'b1, '{16'd0,     16'd65535, 25'd2, 24'd8388480,  23'd8388480, 1'b0}},
      '{16'd65535, 1'b0, 1'b0, '0},
      '{16'd0,     1'b1, 1'b1, '{16'd0,     16'd65535, 25'd2, 24'd8388480,  23'd8388480, 1'b0}},
      '{16'd7,     1'b0, 1'b0, '0},
      '{16'd7,     1'b0, 1'b0, '0},
      '{16'd7,     1'b1, 1'b1, '{16'd7,     16'd7,     25'd3, 24'd1792,     23'd0,       1'b0}},
      '{16'd300,   1'b0, 1'b0, '0},
      '{16'd200,   1'b0, 1'b0, '0},
      '{16'd400,   1'b0, 1'b0, '0},
      '{16'd250,   1'b1, 1'b0, '0},
      '{16'hAAAA,  1'b0, 1'b0, '0},
      '{16'h5555,  1'b0, 1'b0, '0},
      '{16'h8000,  1'b0, 1'b0, '0},
      '{16'h0001,  1'b1, 1'b0, '0},
      '{16'd1,     1'b1, 1'b1, '{16'd1,     16'd1,     25'd1, 24'd256,      23'd0,       1'b0}}
   };

   image_pixel_statistics uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel          (req_pixel),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_min_value      (rsp_min_value),
      .rsp_max_value      (rsp_max_value),
      .rsp_pixel_count    (rsp_pixel_count),
      .rsp_mean_q8        (rsp_mean_q8),
      .rsp_std_q8         (rsp_std_q8),
      .rsp_count_overflow (rsp_count_overflow)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic clear_totals();
      acc_min      = '0;
      acc_max      = '0;
      acc_count    = '0;
      acc_sum      = '0;
      acc_sum_sq   = '0;
      acc_overflow = 1'b0;
   endtask

   task automatic fold_pixel(input logic [IN_PIX_W-1:0] pix);
      logic [PIXEL_BITS-1:0] p;
      p = pix[PIXEL_BITS-1:0];
      if (acc_count < (CNT_W'(1) << COUNT_BITS)) begin
         if (acc_count == '0) begin
            acc_min = p;
            acc_max = p;
         end else begin
            if (p < acc_min) acc_min = p;
            if (p > acc_max) acc_max = p;
         end
         acc_sum    = acc_sum + 64'(p);
         acc_sum_sq = acc_sum_sq + 64'(p) * 64'(p);
         acc_count  = acc_count + CNT_W'(1);
      end else begin
         acc_overflow = 1'b1;
      end
   endtask

   // exact integer mean and population deviation of the current totals
   function automatic image_stats_type close_image();
      logic [191:0]    n, total, squares, num, sum_sqd, den, q;
      logic [63:0]     root, cand;
      logic [127:0]    cand_sq;
      int              bit_i;
      image_stats_type r;
      n       = 192'(acc_count);
      total   = 192'(acc_sum);
      squares = 192'(acc_sum_sq);
      q       = (total << MEAN_SHIFT) / n;
      r.mean_q8 = q[MEAN_W-1:0];
      num     = n * squares;
      sum_sqd = total * total;
      num     = (num > sum_sqd) ? num - sum_sqd : '0;
      num     = num << STD_SHIFT;
      den     = n * n;
      q       = num / den;
      root    = '0;
      for (bit_i = 62; bit_i >= 0; bit_i--) begin
         cand    = root | (64'd1 << bit_i);
         cand_sq = 128'(cand) * 128'(cand);
         if (192'(cand_sq) <= q) root = cand;
      end
      r.std_q8         = root[STD_W-1:0];
      r.min_value      = VAL_W'(acc_min);
      r.max_value      = VAL_W'(acc_max);
      r.pixel_count    = acc_count[OCNT_W-1:0];
      r.count_overflow = acc_overflow;
      return r;
   endfunction

   task automatic drive_pixel(input logic [IN_PIX_W-1:0] pix, input logic last,
                              input logic typed, input image_stats_type want);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      req_last  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      fold_pixel(pix);
      if (last) begin
         if (typed) pending_stats.push_back(want);
         else pending_stats.push_back(close_image());
         clear_totals();
         images_closed++;
      end
   endtask

   function automatic logic [IN_PIX_W-1:0] pick_pixel(input int style,
                                                      input int base);
      case (style)
         0:       return IN_PIX_W'($urandom);
         1:       return IN_PIX_W'(base + $urandom_range(0, 15));
         2:       return $urandom_range(0, 1) ? '1 : '0;
         default: return IN_PIX_W'(base);
      endcase
   endfunction

   task automatic check_field(input string field, input longint unsigned exp_v,
                              input longint unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
         fail_count++;
      end
   endtask

   // result side: random back-pressure, plus one long hold-off so the
   // queue fills and req_ready drops
   initial begin
      int gap;
      image_stats_type want;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && results_taken == 10) begin
            hold_done = 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         results_taken++;
         if (pending_stats.size() == 0) begin
            $display("%0t: result beat with nothing expected", $time);
            fail_count++;
         end else begin
            want = pending_stats.pop_front();
            check_field("min_value", want.min_value, rsp_min_value);
            check_field("max_value", want.max_value, rsp_max_value);
            check_field("pixel_count", want.pixel_count, rsp_pixel_count);
            check_field("mean_q8", want.mean_q8, rsp_mean_q8);
            check_field("std_q8", want.std_q8, rsp_std_q8);
            check_field("count_overflow", want.count_overflow, rsp_count_overflow);
         end
         @(negedge clock);
      end
   end

   initial begin
      int len, style, base, k, row;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_pixel = '0;
      req_last  = 1'b0;
      clear_totals();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < N_DIRECTED; row++) begin
         drive_pixel(directed_rows[row].pixel, directed_rows[row].last,
                     directed_rows[row].typed, directed_rows[row].want);
      end

      // short images first so they pile up during the long hold-off
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (images_closed < N_DIRECTED + 30) len = $urandom_range(1, 4);
         else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: len = $urandom_range(1, 8);
               6, 7, 8:          len = $urandom_range(9, 40);
               default:          len = $urandom_range(100, 300);
            endcase
         end
         style        = $urandom_range(0, 3);
         base         = $urandom_range(0, 65520);
         sender_quiet = ($urandom_range(0, 3) == 0);
         for (k = 0; k < len; k++) begin
            drive_pixel(pick_pixel(style, base), k == len - 1, 1'b0, '0);
         end
      end
      sender_quiet = 0;
      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
